### rtl/ert_pkg.sv
// Shared types, constants and the arctangent table for the effective rigid transform.
`default_nettype none

package ert_pkg;

   localparam int MAX_STAGES = 24;

   // Angles in 1/1024 degree.
   localparam logic signed [22:0] FULL_TURN    = 23'sd368640;
   localparam logic signed [22:0] HALF_TURN    = 23'sd184320;
   localparam logic signed [22:0] QUARTER_TURN = 23'sd92160;

   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [32:0] Q30_HALF_LSB = 33'sd32768;
   localparam logic signed [16:0] Q14_ONE = 17'sd16384;

   // atan(2^-i) in 1/65536 degree.
   localparam logic [22:0] ATAN_TABLE [MAX_STAGES] = '{
      23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
      23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
      23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
      23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
   };

   typedef struct packed {
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic signed [24:0] z;
      logic               flip;
   } cordic_type;

endpackage

`default_nettype wire

### rtl/effective_rigid_transform.sv
// Top level: effective transform of a detector placement relative to a reference placement.
//
// A command is transferred at a rising clock edge with start high and busy low. busy is
// always low: the block takes a new placement pair in every cycle.
// Each command yields exactly one result, shown on the rsp_ ports for one cycle with
// rsp_valid high. The command passes through the two chains of rotation cells that
// compute the sine and cosine of the effective and of the reference angle (one cell
// per iteration, plus range reduction, folding and rounding), followed by a multiply
// stage, a partial sum stage and a final round and saturate stage.
// Results leave in command order. The receiver cannot stall the block, so a result
// not taken in its cycle is gone.
// A synchronous reset clears the valid pipeline; results of commands in flight are
// dropped and the first command after reset is handled normally.
`default_nettype none

module effective_rigid_transform #(
   parameter int ANGLE_STAGES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [23:0] req_det_x,
   input  wire logic signed [23:0] req_det_y,
   input  wire logic signed [23:0] req_det_z,
   input  wire logic signed [23:0] req_det_centre_x,
   input  wire logic signed [23:0] req_det_centre_z,
   input  wire logic signed [19:0] req_det_angle,
   input  wire logic signed [23:0] req_ref_x,
   input  wire logic signed [23:0] req_ref_y,
   input  wire logic signed [23:0] req_ref_z,
   input  wire logic signed [23:0] req_ref_centre_x,
   input  wire logic signed [23:0] req_ref_centre_z,
   input  wire logic signed [19:0] req_ref_angle,
   output logic                    rsp_valid,
   output logic signed [25:0]      rsp_eff_x,
   output logic signed [25:0]      rsp_eff_y,
   output logic signed [25:0]      rsp_eff_z,
   output logic signed [20:0]      rsp_eff_angle,
   output logic signed [15:0]      rsp_eff_sine,
   output logic signed [15:0]      rsp_eff_cosine
);
   import ert_pkg::*;

   localparam int ALIGN = ANGLE_STAGES + 3;
   localparam int TOTAL = ANGLE_STAGES + 6;
   localparam logic signed [45:0] ROUND_HALF = 46'sd8192;
   localparam logic signed [31:0] SAT_MAX = 32'sd33554431;
   localparam logic signed [31:0] SAT_MIN = -32'sd33554432;

   typedef struct packed {
      logic signed [25:0] relx;
      logic signed [25:0] relz;
      logic signed [23:0] dcx;
      logic signed [23:0] dcz;
      logic signed [23:0] rcx;
      logic signed [23:0] rcz;
      logic signed [25:0] ey;
      logic signed [20:0] ea;
      logic               same;
   } carry_type;

   typedef struct packed {
      logic signed [41:0] c_relx;
      logic signed [41:0] s_relz;
      logic signed [41:0] ec_dcx;
      logic signed [41:0] es_dcz;
      logic signed [41:0] s_relx;
      logic signed [41:0] c_relz;
      logic signed [41:0] es_dcx;
      logic signed [41:0] ec_dcz;
      logic signed [23:0] rcx;
      logic signed [23:0] rcz;
      logic signed [25:0] ey;
      logic signed [20:0] ea;
      logic signed [15:0] es;
      logic signed [15:0] ec;
   } prod_type;

   typedef struct packed {
      logic signed [45:0] px;
      logic signed [45:0] qx;
      logic signed [45:0] pz;
      logic signed [45:0] qz;
      logic signed [25:0] ey;
      logic signed [20:0] ea;
      logic signed [15:0] es;
      logic signed [15:0] ec;
   } part_type;

   logic               valid_ff [TOTAL];
   carry_type          carry_ff [ALIGN];
   carry_type          carry_in;
   prod_type           prod_ff;
   prod_type           prod_in;
   part_type           part_ff;
   part_type           part_in;
   logic signed [20:0] eff_angle;
   logic signed [15:0] eff_sin;
   logic signed [15:0] eff_cos;
   logic signed [15:0] ref_sin;
   logic signed [15:0] ref_cos;
   logic signed [15:0] es_sel;
   logic signed [15:0] ec_sel;
   logic signed [45:0] sum_x;
   logic signed [45:0] sum_z;
   logic signed [31:0] round_x;
   logic signed [31:0] round_z;
   logic signed [25:0] out_x_in;
   logic signed [25:0] out_z_in;
   logic signed [25:0] out_x_ff;
   logic signed [25:0] out_z_ff;
   logic signed [25:0] out_y_ff;
   logic signed [20:0] out_angle_ff;
   logic signed [15:0] out_sine_ff;
   logic signed [15:0] out_cosine_ff;
   logic               accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign eff_angle = 21'(req_det_angle) - 21'(req_ref_angle);

   ert_sincos #(.ANGLE_STAGES(ANGLE_STAGES)) u_eff_sincos (
      .clock  (clock),
      .angle  (eff_angle),
      .sine   (eff_sin),
      .cosine (eff_cos)
   );

   ert_sincos #(.ANGLE_STAGES(ANGLE_STAGES)) u_ref_sincos (
      .clock  (clock),
      .angle  (21'(req_ref_angle)),
      .sine   (ref_sin),
      .cosine (ref_cos)
   );

   always_comb begin
      carry_in.relx = 26'(req_det_x) + 26'(req_det_centre_x)
                    - 26'(req_ref_x) - 26'(req_ref_centre_x);
      carry_in.relz = 26'(req_det_z) + 26'(req_det_centre_z)
                    - 26'(req_ref_z) - 26'(req_ref_centre_z);
      carry_in.dcx  = req_det_centre_x;
      carry_in.dcz  = req_det_centre_z;
      carry_in.rcx  = req_ref_centre_x;
      carry_in.rcz  = req_ref_centre_z;
      carry_in.ey   = 26'(req_det_y) - 26'(req_ref_y);
      carry_in.ea   = eff_angle;
      carry_in.same = (req_det_angle == req_ref_angle);
   end

   always_ff @(posedge clock) begin
      carry_ff[0] <= carry_in;
      for (int i = 1; i < ALIGN; i++) begin
         carry_ff[i] <= carry_ff[i-1];
      end
   end

   // Identical angles give an exact zero rotation.
   always_comb begin
      es_sel = carry_ff[ALIGN-1].same ? 16'sd0 : eff_sin;
      ec_sel = carry_ff[ALIGN-1].same ? 16'(Q14_ONE) : eff_cos;
      prod_in.c_relx = ref_cos * carry_ff[ALIGN-1].relx;
      prod_in.s_relz = ref_sin * carry_ff[ALIGN-1].relz;
      prod_in.ec_dcx = ec_sel * carry_ff[ALIGN-1].dcx;
      prod_in.es_dcz = es_sel * carry_ff[ALIGN-1].dcz;
      prod_in.s_relx = ref_sin * carry_ff[ALIGN-1].relx;
      prod_in.c_relz = ref_cos * carry_ff[ALIGN-1].relz;
      prod_in.es_dcx = es_sel * carry_ff[ALIGN-1].dcx;
      prod_in.ec_dcz = ec_sel * carry_ff[ALIGN-1].dcz;
      prod_in.rcx    = carry_ff[ALIGN-1].rcx;
      prod_in.rcz    = carry_ff[ALIGN-1].rcz;
      prod_in.ey     = carry_ff[ALIGN-1].ey;
      prod_in.ea     = carry_ff[ALIGN-1].ea;
      prod_in.es     = es_sel;
      prod_in.ec     = ec_sel;
   end

   always_comb begin
      part_in.px = (46'(prod_ff.rcx) <<< 14) + 46'(prod_ff.c_relx) + 46'(prod_ff.s_relz);
      part_in.qx = 46'(prod_ff.ec_dcx) + 46'(prod_ff.es_dcz);
      part_in.pz = (46'(prod_ff.rcz) <<< 14) - 46'(prod_ff.s_relx) + 46'(prod_ff.c_relz);
      part_in.qz = 46'(prod_ff.ec_dcz) - 46'(prod_ff.es_dcx);
      part_in.ey = prod_ff.ey;
      part_in.ea = prod_ff.ea;
      part_in.es = prod_ff.es;
      part_in.ec = prod_ff.ec;
   end

   // Round half up from Q14, then saturate to the output range.
   always_comb begin
      sum_x   = part_ff.px - part_ff.qx;
      sum_z   = part_ff.pz - part_ff.qz;
      round_x = 32'((sum_x + ROUND_HALF) >>> 14);
      round_z = 32'((sum_z + ROUND_HALF) >>> 14);
      out_x_in = (round_x > SAT_MAX) ? 26'(SAT_MAX) :
                 (round_x < SAT_MIN) ? 26'(SAT_MIN) : 26'(round_x);
      out_z_in = (round_z > SAT_MAX) ? 26'(SAT_MAX) :
                 (round_z < SAT_MIN) ? 26'(SAT_MIN) : 26'(round_z);
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      part_ff       <= part_in;
      out_x_ff      <= out_x_in;
      out_z_ff      <= out_z_in;
      out_y_ff      <= part_ff.ey;
      out_angle_ff  <= part_ff.ea;
      out_sine_ff   <= part_ff.es;
      out_cosine_ff <= part_ff.ec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= accept;
         for (int i = 1; i < TOTAL; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign rsp_valid      = valid_ff[TOTAL-1];
   assign rsp_eff_x      = out_x_ff;
   assign rsp_eff_y      = out_y_ff;
   assign rsp_eff_z      = out_z_ff;
   assign rsp_eff_angle  = out_angle_ff;
   assign rsp_eff_sine   = out_sine_ff;
   assign rsp_eff_cosine = out_cosine_ff;

   a_result_has_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, TOTAL))
      else $error("result without a matching command transfer");

   a_zero_angle_exact: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_eff_angle == 21'sd0) |->
         (rsp_eff_sine == 16'sd0 && rsp_eff_cosine == 16'sd16384))
      else $error("zero effective angle without an exact zero rotation");

   a_sine_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_eff_sine <= 16'sd16384 && rsp_eff_sine >= -16'sd16384 &&
                     rsp_eff_cosine <= 16'sd16384 && rsp_eff_cosine >= -16'sd16384))
      else $error("sine or cosine beyond unity");

endmodule

`default_nettype wire

### rtl/ert_cell.sv
// One registered rotation step of the sine and cosine chain.
`default_nettype none

module ert_cell #(
   parameter int STAGE = 0
) (
   input  wire logic               clock,
   input  wire ert_pkg::cordic_type prev_cell,
   output ert_pkg::cordic_type     next_cell
);
   import ert_pkg::*;

   cordic_type         stage_ff;
   cordic_type         stage_in;
   logic signed [32:0] x_shift;
   logic signed [32:0] y_shift;
   logic signed [24:0] step;

   always_comb begin
      x_shift = prev_cell.x >>> STAGE;
      y_shift = prev_cell.y >>> STAGE;
      step = $signed({2'b00, ATAN_TABLE[STAGE]});
      stage_in.flip = prev_cell.flip;
      // A residual of zero counts as positive.
      if (!prev_cell.z[24]) begin
         stage_in.x = prev_cell.x - y_shift;
         stage_in.y = prev_cell.y + x_shift;
         stage_in.z = prev_cell.z - step;
      end else begin
         stage_in.x = prev_cell.x + y_shift;
         stage_in.y = prev_cell.y - x_shift;
         stage_in.z = prev_cell.z + step;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign next_cell = stage_ff;

endmodule

`default_nettype wire

### rtl/ert_sincos.sv
// Pipelined sine and cosine: range reduction, a chain of rotation cells, rounding.
`default_nettype none

module ert_sincos #(
   parameter int ANGLE_STAGES = 16
) (
   input  wire logic               clock,
   input  wire logic signed [20:0] angle,
   output logic signed [15:0]      sine,
   output logic signed [15:0]      cosine
);
   import ert_pkg::*;

   localparam int CELLS = (ANGLE_STAGES < MAX_STAGES) ? ANGLE_STAGES : MAX_STAGES;

   logic signed [22:0] wide_angle;
   logic signed [22:0] shifted;
   logic signed [22:0] reduced;
   logic signed [18:0] red_ff;
   logic signed [17:0] folded;
   cordic_type         head_in;
   cordic_type         head_ff;
   cordic_type         chain [CELLS+1];
   logic signed [16:0] cos_round;
   logic signed [16:0] sin_round;
   logic signed [16:0] cos_clamp;
   logic signed [16:0] sin_clamp;
   logic signed [15:0] sine_in;
   logic signed [15:0] cosine_in;
   logic signed [15:0] sine_ff;
   logic signed [15:0] cosine_ff;

   // Bring the angle into [-180, 180) degrees; at most three turns either way.
   always_comb begin
      wide_angle = 23'(angle);
      shifted = wide_angle + HALF_TURN;
      if (shifted >= 23'sd1105920) begin
         reduced = wide_angle - 23'sd1105920;
      end else if (shifted >= 23'sd737280) begin
         reduced = wide_angle - 23'sd737280;
      end else if (shifted >= FULL_TURN) begin
         reduced = wide_angle - FULL_TURN;
      end else if (shifted < -23'sd737280) begin
         reduced = wide_angle + 23'sd1105920;
      end else if (shifted < -FULL_TURN) begin
         reduced = wide_angle + 23'sd737280;
      end else if (shifted < 23'sd0) begin
         reduced = wide_angle + FULL_TURN;
      end else begin
         reduced = wide_angle;
      end
   end

   // Fold into [-90, 90] degrees and remember to negate the outputs.
   always_comb begin
      head_in.flip = 1'b0;
      if (23'(red_ff) > QUARTER_TURN) begin
         folded = 18'(23'(red_ff) - HALF_TURN);
         head_in.flip = 1'b1;
      end else if (23'(red_ff) < -QUARTER_TURN) begin
         folded = 18'(23'(red_ff) + HALF_TURN);
         head_in.flip = 1'b1;
      end else begin
         folded = 18'(red_ff);
      end
      head_in.x = CORDIC_GAIN;
      head_in.y = 33'sd0;
      head_in.z = 25'(folded) <<< 6;
   end

   always_ff @(posedge clock) begin
      red_ff  <= 19'(reduced);
      head_ff <= head_in;
   end

   assign chain[0] = head_ff;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      ert_cell #(.STAGE(i)) u_cell (
         .clock     (clock),
         .prev_cell (chain[i]),
         .next_cell (chain[i+1])
      );
   end

   always_comb begin
      cos_round = 17'((chain[CELLS].x + Q30_HALF_LSB) >>> 16);
      sin_round = 17'((chain[CELLS].y + Q30_HALF_LSB) >>> 16);
      cos_clamp = (cos_round > Q14_ONE) ? Q14_ONE :
                  (cos_round < -Q14_ONE) ? -Q14_ONE : cos_round;
      sin_clamp = (sin_round > Q14_ONE) ? Q14_ONE :
                  (sin_round < -Q14_ONE) ? -Q14_ONE : sin_round;
      if (chain[CELLS].flip) begin
         cosine_in = 16'(-cos_clamp);
         sine_in   = 16'(-sin_clamp);
      end else begin
         cosine_in = 16'(cos_clamp);
         sine_in   = 16'(sin_clamp);
      end
   end

   always_ff @(posedge clock) begin
      sine_ff   <= sine_in;
      cosine_ff <= cosine_in;
   end

   assign sine   = sine_ff;
   assign cosine = cosine_ff;

endmodule

`default_nettype wire
